// ===== hdl/dpcm_pkg.sv =====
// dpcm_pkg: shared types, codes and the rate table of the delta-modulation sample channel
// used by dpcm_step and dpcm_sample_channel; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package dpcm_pkg;

   // item kinds
   localparam logic [1:0] KindTick  = 2'd0;
   localparam logic [1:0] KindWrite = 2'd1;
   localparam logic [1:0] KindLoad  = 2'd2;

   // register selects
   localparam logic [2:0] RegControl = 3'd0;
   localparam logic [2:0] RegLevel   = 3'd1;
   localparam logic [2:0] RegAddress = 3'd2;
   localparam logic [2:0] RegLength  = 3'd3;
   localparam logic [2:0] RegEnable  = 3'd4;

   // reset values and fixed addresses
   localparam logic [8:0]  PeriodReset    = 9'd428;
   localparam logic [15:0] StartAddrBase  = 16'hC000;
   localparam logic [15:0] WrapAddr       = 16'h8000;
   localparam logic [12:0] SampleBytesRst = 13'd1;
   localparam logic [3:0]  BitsPerByte    = 4'd8;
   localparam logic [6:0]  LevelTop       = 7'd125;

   typedef struct packed {
      logic [8:0]  timer_count;
      logic [8:0]  timer_period;
      logic        irq_enable;
      logic        loop_mode;
      logic [6:0]  out_level;
      logic [15:0] start_address;
      logic [12:0] sample_bytes;
      logic [15:0] current_address;
      logic [12:0] bytes_left;
      logic [3:0]  bits_left;
      logic [7:0]  shifter;
      logic [7:0]  buffer_byte;
      logic        buffer_full;
      logic        silent;
      logic        channel_on;
      logic        irq_flag;
   } dpcm_state_type;

   typedef struct packed {
      logic [6:0]  level;
      logic        fetch_request;
      logic [15:0] fetch_address;
      logic        irq_pending;
      logic        active;
   } dpcm_result_type;

   // rate index to timer period
   function automatic logic [8:0] rate_period(input logic [3:0] idx);
      logic [8:0] p;
      case (idx)
         4'd0:    p = 9'd428;
         4'd1:    p = 9'd380;
         4'd2:    p = 9'd340;
         4'd3:    p = 9'd320;
         4'd4:    p = 9'd286;
         4'd5:    p = 9'd254;
         4'd6:    p = 9'd226;
         4'd7:    p = 9'd214;
         4'd8:    p = 9'd190;
         4'd9:    p = 9'd160;
         4'd10:   p = 9'd142;
         4'd11:   p = 9'd128;
         4'd12:   p = 9'd106;
         4'd13:   p = 9'd84;
         4'd14:   p = 9'd72;
         default: p = 9'd54;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dpcm_step.sv =====
// dpcm_step: next channel state and result for one item, purely combinational
// depends on dpcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpcm_step (
   input  dpcm_pkg::dpcm_state_type  state_cur,
   input  logic [1:0]                kind,
   input  logic [2:0]                reg_select,
   input  logic [7:0]                write_data,
   input  logic [7:0]                sample_byte,
   output dpcm_pkg::dpcm_state_type  state_nxt,
   output dpcm_pkg::dpcm_result_type result
);

   dpcm_pkg::dpcm_state_type s;
   logic                     fetch_ok;
   logic [15:0]              addr_inc;
   logic [12:0]              left_dec;

   assign fetch_ok = state_cur.channel_on && !state_cur.buffer_full &&
                     (state_cur.bytes_left != 13'd0);
   assign addr_inc = state_cur.current_address + 16'd1;
   assign left_dec = state_cur.bytes_left - 13'd1;

   always_comb begin
      s = state_cur;
      case (kind)
         dpcm_pkg::KindTick: begin
            if (state_cur.timer_count != 9'd0) begin
               s.timer_count = state_cur.timer_count - 9'd1;
            end else begin
               // new byte every eight output bits
               if (state_cur.bits_left == 4'd0) begin
                  s.bits_left = dpcm_pkg::BitsPerByte;
                  if (state_cur.buffer_full) begin
                     s.silent      = 1'b0;
                     s.shifter     = state_cur.buffer_byte;
                     s.buffer_full = 1'b0;
                  end else begin
                     s.silent = 1'b1;
                  end
               end
               if (!s.silent) begin
                  if (s.shifter[0]) begin
                     if (s.out_level <= dpcm_pkg::LevelTop) begin
                        s.out_level = s.out_level + 7'd2;
                     end
                  end else begin
                     if (s.out_level >= 7'd2) begin
                        s.out_level = s.out_level - 7'd2;
                     end
                  end
               end
               s.shifter     = {1'b0, s.shifter[7:1]};
               s.bits_left   = s.bits_left - 4'd1;
               s.timer_count = state_cur.timer_period;
            end
         end
         dpcm_pkg::KindWrite: begin
            unique case (reg_select)
               dpcm_pkg::RegControl: begin
                  s.irq_enable   = write_data[7];
                  s.loop_mode    = write_data[6];
                  s.timer_period = dpcm_pkg::rate_period(write_data[3:0]);
                  if (!write_data[7]) begin
                     s.irq_flag = 1'b0;
                  end
               end
               dpcm_pkg::RegLevel: begin
                  s.out_level = write_data[6:0];
               end
               dpcm_pkg::RegAddress: begin
                  s.start_address = dpcm_pkg::StartAddrBase + {2'b00, write_data, 6'b000000};
               end
               dpcm_pkg::RegLength: begin
                  s.sample_bytes = {1'b0, write_data, 4'b0001};
               end
               dpcm_pkg::RegEnable: begin
                  s.channel_on = (write_data != 8'd0);
                  if (write_data != 8'd0) begin
                     if (state_cur.bytes_left == 13'd0) begin
                        s.current_address = state_cur.start_address;
                        s.bytes_left      = state_cur.sample_bytes;
                     end
                  end else begin
                     s.bytes_left = 13'd0;
                  end
                  s.irq_flag = 1'b0;
               end
               default: begin
               end
            endcase
         end
         dpcm_pkg::KindLoad: begin
            // unrequested bytes are dropped
            if (fetch_ok) begin
               s.buffer_full     = 1'b1;
               s.buffer_byte     = sample_byte;
               s.current_address = (addr_inc == 16'd0) ? dpcm_pkg::WrapAddr : addr_inc;
               s.bytes_left      = left_dec;
               if (left_dec == 13'd0) begin
                  if (state_cur.loop_mode) begin
                     s.current_address = state_cur.start_address;
                     s.bytes_left      = state_cur.sample_bytes;
                  end else if (state_cur.irq_enable) begin
                     s.irq_flag = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign state_nxt            = s;
   assign result.level         = s.out_level;
   assign result.fetch_request = s.channel_on && !s.buffer_full && (s.bytes_left != 13'd0);
   assign result.fetch_address = s.current_address;
   assign result.irq_pending   = s.irq_flag;
   assign result.active        = (s.bytes_left != 13'd0);

endmodule

`default_nettype wire

// ===== hdl/dpcm_sample_channel.sv =====
// dpcm_sample_channel: top level of the delta-modulation sample channel
// depends on dpcm_pkg and dpcm_step
`timescale 1ns / 1ps
`default_nettype none

// The channel takes one item per clock while req_ready is high: a timer
// tick, a register write or a fetched sample byte, chosen by req_kind. Each
// item is captured in an input register, applied to the channel state in one
// pass of combinational logic, and its result (level, fetch request and
// address, interrupt flag, active) lands in an output register once it is
// free or being taken; with rsp_ready high the rate is one item per cycle.
// The input and result registers part the two sides: while a result waits
// to be taken, one more item is held, and req_ready only drops when both are
// full and rsp_ready is low. Reset clears the channel to its power-up state
// (rate index 0, start address 0xC000, length 1, silent, disabled).
module dpcm_sample_channel (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_sample_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_level,
   output logic        rsp_fetch_request,
   output logic [15:0] rsp_fetch_address,
   output logic        rsp_irq_pending,
   output logic        rsp_active
);

   // input register
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [2:0] in_sel_ff;
   logic [7:0] in_data_ff;
   logic [7:0] in_byte_ff;

   // channel state and result register
   dpcm_pkg::dpcm_state_type  state_ff, state_in;
   dpcm_pkg::dpcm_result_type result_ff, result_in;
   logic                      rsp_valid_ff;

   logic advance;
   logic req_take;

   // item moves from the input register into the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   dpcm_step u_step (
      .state_cur   (state_ff),
      .kind        (in_kind_ff),
      .reg_select  (in_sel_ff),
      .write_data  (in_data_ff),
      .sample_byte (in_byte_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   // input register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register: payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_sel_ff  <= req_reg_select;
         in_data_ff <= req_write_data;
         in_byte_ff <= req_sample_byte;
      end
   end

   // channel state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.timer_count     <= 9'd0;
         state_ff.timer_period    <= dpcm_pkg::PeriodReset;
         state_ff.irq_enable      <= 1'b0;
         state_ff.loop_mode       <= 1'b0;
         state_ff.out_level       <= 7'd0;
         state_ff.start_address   <= dpcm_pkg::StartAddrBase;
         state_ff.sample_bytes    <= dpcm_pkg::SampleBytesRst;
         state_ff.current_address <= 16'd0;
         state_ff.bytes_left      <= 13'd0;
         state_ff.bits_left       <= 4'd0;
         state_ff.shifter         <= 8'd0;
         state_ff.buffer_byte     <= 8'd0;
         state_ff.buffer_full     <= 1'b0;
         state_ff.silent          <= 1'b1;
         state_ff.channel_on      <= 1'b0;
         state_ff.irq_flag        <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register: payload
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = result_ff.level;
   assign rsp_fetch_request = result_ff.fetch_request;
   assign rsp_fetch_address = result_ff.fetch_address;
   assign rsp_irq_pending   = result_ff.irq_pending;
   assign rsp_active        = result_ff.active;

   // a fetch is only ever asked for while bytes remain
   a_fetch_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!result_ff.fetch_request || result_ff.active))
      else $error("fetch request without bytes left");

   // bit counter never exceeds one byte
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bits_left <= dpcm_pkg::BitsPerByte)
      else $error("bits_left out of range");

   // timer never loaded above the slowest period
   a_timer_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.timer_count <= dpcm_pkg::PeriodReset)
      else $error("timer count out of range");

   // a held item reaches the empty result register next cycle
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("held item did not advance");

   // reset leaves the channel silent and both registers empty
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> (state_ff.silent && !in_valid_ff && !rsp_valid_ff))
      else $error("bad state after reset");

endmodule

`default_nettype wire
